// ----- rtl/core/tfds_pkg.sv -----
// Package for the touch frame decode and scale unit: types, constants, register indexes.
package tfds_pkg;

   // Native touch grid of the controller
   localparam int unsigned NATIVE_WIDTH  = 258;
   localparam int unsigned NATIVE_HEIGHT = 960;

   // Register reset values
   localparam logic [11:0] DISPLAY_WIDTH_RESET  = 12'(NATIVE_WIDTH);
   localparam logic [11:0] DISPLAY_HEIGHT_RESET = 12'(NATIVE_HEIGHT);
   localparam logic [7:0]  FAIL_LIMIT_RESET     = 8'd50;
   localparam logic [15:0] RETRY_INTERVAL_RESET = 16'd5000;

   // Register indexes
   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISPLAY_WIDTH  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISPLAY_HEIGHT = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAIL_LIMIT     = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RETRY_INTERVAL = 8'd3;

   // Request action codes
   localparam logic ACTION_POLL      = 1'b0;
   localparam logic ACTION_RECONNECT = 1'b1;

   // Event codes that carry a contact
   localparam logic [1:0] EVENT_DOWN    = 2'd0;
   localparam logic [1:0] EVENT_CONTACT = 2'd2;

   // Frame field masks
   localparam logic [7:0] NIBBLE_MASK = 8'h0F;
   localparam logic [1:0] EVENT_MASK  = 2'h3;

   // Scaling products: raw coordinate (inside grid) times a 12-bit display size
   localparam int unsigned PROD_X_W = 21;
   localparam int unsigned PROD_Y_W = 22;

   // Exact reciprocals for truncating division of the products by the native size
   localparam int unsigned RECIP_W       = 24;
   localparam int unsigned RECIP_X_SHIFT = 30;
   localparam int unsigned RECIP_Y_SHIFT = 32;
   localparam longint unsigned RECIP_X_L =
      ((64'd1 << RECIP_X_SHIFT) + NATIVE_WIDTH - 1) / NATIVE_WIDTH;
   localparam longint unsigned RECIP_Y_L =
      ((64'd1 << RECIP_Y_SHIFT) + NATIVE_HEIGHT - 1) / NATIVE_HEIGHT;
   localparam logic [RECIP_W-1:0] RECIP_X = RECIP_W'(RECIP_X_L);
   localparam logic [RECIP_W-1:0] RECIP_Y = RECIP_W'(RECIP_Y_L);

   localparam logic [7:0] FAIL_COUNT_MAX = 8'hFF;

   typedef struct packed {
      logic        action;
      logic        transfer_ok;
      logic [7:0]  count_byte;
      logic [7:0]  event_xhigh_byte;
      logic [7:0]  x_low_byte;
      logic [7:0]  y_high_byte;
      logic [7:0]  y_low_byte;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic        pressed;
      logic [11:0] touch_x;
      logic [11:0] touch_y;
      logic        link_down;
      logic        retry_due;
      logic [31:0] last_activity_ms;
   } rsp_type;

endpackage

// ----- rtl/core/touch_frame_decode_scale_unit.sv -----
// Touch frame decode and scale unit: decode, scale and link-health tracking in one pipeline.
// Throughput: one request per cycle unless rsp_ready stalls the pipeline; the input
// register, the product register and the response register each hold one request,
// so up to three requests are in flight.
// The pace is set by the combinational scale multiply and the reciprocal divide stage.
// Reset (synchronous, active high) empties the pipeline, clears the link tracker, held
// point and activity time, and loads the register defaults.
module touch_frame_decode_scale_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  tfds_pkg::req_type                  req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output tfds_pkg::rsp_type                  rsp_payload,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tfds_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tfds_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import tfds_pkg::*;

   typedef struct packed {
      logic                action;
      logic                transfer_ok;
      logic                frame_good;
      logic [31:0]         now_ms;
      logic [PROD_X_W-1:0] prod_x;
      logic [PROD_Y_W-1:0] prod_y;
   } mul_type;

   // Configuration registers
   logic [11:0] display_width_ff;
   logic [11:0] display_height_ff;
   logic [7:0]  fail_limit_ff;
   logic [15:0] retry_interval_ff;

   // Tracker and held state
   logic [7:0]  failure_count_ff, failure_count_in;
   logic        link_lost_ff, link_lost_in;
   logic [31:0] down_since_ff, down_since_in;
   logic [11:0] held_x_ff, held_x_in;
   logic [11:0] held_y_ff, held_y_in;
   logic [31:0] activity_ff, activity_in;

   // Pipeline registers
   logic    in_vld_ff, mul_vld_ff, rsp_vld_ff;
   req_type in_ff;
   mul_type mul_ff, mul_in;
   rsp_type rsp_ff, rsp_in;

   logic rsp_load, mul_load, in_load;

   // Pipeline flow: each stage loads when it is empty or its content moves on
   assign rsp_load    = !rsp_vld_ff || rsp_ready;
   assign mul_load    = !mul_vld_ff || rsp_load;
   assign in_load     = !in_vld_ff || mul_load;
   assign req_ready   = in_load;
   assign rsp_valid   = rsp_vld_ff;
   assign rsp_payload = rsp_ff;
   assign csr_ready   = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         mul_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (in_load) in_vld_ff <= req_valid;
         if (mul_load) mul_vld_ff <= in_vld_ff;
         if (rsp_load) rsp_vld_ff <= mul_vld_ff;
      end
   end

   // Capture the request
   always_ff @(posedge clock) begin
      if (in_load && req_valid) in_ff <= req_payload;
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         display_width_ff  <= DISPLAY_WIDTH_RESET;
         display_height_ff <= DISPLAY_HEIGHT_RESET;
         fail_limit_ff     <= FAIL_LIMIT_RESET;
         retry_interval_ff <= RETRY_INTERVAL_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DISPLAY_WIDTH:  display_width_ff  <= csr_wdata[11:0];
            CSR_DISPLAY_HEIGHT: display_height_ff <= csr_wdata[11:0];
            CSR_FAIL_LIMIT:     fail_limit_ff     <= csr_wdata[7:0];
            CSR_RETRY_INTERVAL: retry_interval_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Decode the frame and multiply the raw point by the display size
   logic [1:0]  ev;
   logic [11:0] raw_x, raw_y;
   logic [23:0] full_x, full_y;
   always_comb begin
      ev     = in_ff.event_xhigh_byte[7:6] & EVENT_MASK;
      raw_x  = {in_ff.event_xhigh_byte[3:0] & NIBBLE_MASK[3:0], in_ff.x_low_byte};
      raw_y  = {in_ff.y_high_byte[3:0] & NIBBLE_MASK[3:0], in_ff.y_low_byte};
      full_x = {12'd0, raw_x} * {12'd0, display_width_ff};
      full_y = {12'd0, raw_y} * {12'd0, display_height_ff};
      mul_in.action      = in_ff.action;
      mul_in.transfer_ok = in_ff.transfer_ok;
      mul_in.frame_good  = (in_ff.count_byte != 8'd0)
                         && (ev == EVENT_DOWN || ev == EVENT_CONTACT)
                         && (raw_x < 12'(NATIVE_WIDTH))
                         && (raw_y < 12'(NATIVE_HEIGHT));
      mul_in.now_ms      = in_ff.now_ms;
      mul_in.prod_x      = full_x[PROD_X_W-1:0];
      mul_in.prod_y      = full_y[PROD_Y_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (mul_load && in_vld_ff) mul_ff <= mul_in;
   end

   // Divide the products by the native size through exact reciprocals
   logic [PROD_X_W+RECIP_W-1:0] quot_x_full;
   logic [PROD_Y_W+RECIP_W-1:0] quot_y_full;
   logic [11:0] scaled_x, scaled_y;
   assign quot_x_full = {{RECIP_W{1'b0}}, mul_ff.prod_x} * {{PROD_X_W{1'b0}}, RECIP_X};
   assign quot_y_full = {{RECIP_W{1'b0}}, mul_ff.prod_y} * {{PROD_Y_W{1'b0}}, RECIP_Y};
   assign scaled_x    = quot_x_full[RECIP_X_SHIFT +: 12];
   assign scaled_y    = quot_y_full[RECIP_Y_SHIFT +: 12];

   // Update the link tracker and the held point, build the response
   logic [7:0]  fail_bump;
   logic [31:0] since;
   logic        pressed, retry;
   always_comb begin
      failure_count_in = failure_count_ff;
      link_lost_in     = link_lost_ff;
      down_since_in    = down_since_ff;
      held_x_in        = held_x_ff;
      held_y_in        = held_y_ff;
      activity_in      = activity_ff;
      pressed          = 1'b0;
      retry            = 1'b0;
      fail_bump        = (failure_count_ff < FAIL_COUNT_MAX) ? failure_count_ff + 8'd1
                                                             : failure_count_ff;
      since            = mul_ff.now_ms - down_since_ff;
      if (mul_ff.action == ACTION_RECONNECT) begin
         link_lost_in     = 1'b0;
         failure_count_in = 8'd0;
      end else if (link_lost_ff) begin
         if (since >= {16'd0, retry_interval_ff}) begin
            down_since_in = mul_ff.now_ms;
            retry         = 1'b1;
         end
      end else if (!mul_ff.transfer_ok) begin
         failure_count_in = fail_bump;
         if (fail_bump >= fail_limit_ff) begin
            link_lost_in  = 1'b1;
            down_since_in = mul_ff.now_ms;
         end
      end else begin
         failure_count_in = 8'd0;
         if (mul_ff.frame_good) begin
            held_x_in   = scaled_x;
            held_y_in   = scaled_y;
            activity_in = mul_ff.now_ms;
            pressed     = 1'b1;
         end
      end
      rsp_in.pressed          = pressed;
      rsp_in.touch_x          = held_x_in;
      rsp_in.touch_y          = held_y_in;
      rsp_in.link_down        = link_lost_in;
      rsp_in.retry_due        = retry;
      rsp_in.last_activity_ms = activity_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         failure_count_ff <= 8'd0;
         link_lost_ff     <= 1'b0;
         down_since_ff    <= 32'd0;
         held_x_ff        <= 12'd0;
         held_y_ff        <= 12'd0;
         activity_ff      <= 32'd0;
      end else if (rsp_load && mul_vld_ff) begin
         failure_count_ff <= failure_count_in;
         link_lost_ff     <= link_lost_in;
         down_since_ff    <= down_since_in;
         held_x_ff        <= held_x_in;
         held_y_ff        <= held_y_in;
         activity_ff      <= activity_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load && mul_vld_ff) rsp_ff <= rsp_in;
   end

   // A contact is only reported while the link is up
   a_pressed_link_up: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_ff.pressed |-> !rsp_ff.link_down)
      else $error("contact reported with link down");

   // A retry request only comes while the link is down
   a_retry_link_down: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_ff.retry_due |-> rsp_ff.link_down)
      else $error("retry requested with link up");

   // An accepted request occupies the input register next cycle
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> in_vld_ff)
      else $error("accepted request lost");

   // A stalled product stage keeps its content
   a_mul_hold: assert property (@(posedge clock) disable iff (reset)
      mul_vld_ff && !rsp_load |=> mul_vld_ff && $stable(mul_ff))
      else $error("product stage changed while stalled");

   // Tracker state moves only when a request reaches the response register
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !(rsp_load && mul_vld_ff) |=> $stable(failure_count_ff) && $stable(link_lost_ff))
      else $error("tracker state changed without a request");

endmodule

// ----- dv/tb_top.sv -----
// Testbench for the touch frame decode and scale unit: directed and random polls, scoreboard check.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import tfds_pkg::*;

   // Event codes that carry no contact
   localparam logic [1:0] EVENT_UP       = 2'd1;
   localparam logic [1:0] EVENT_RESERVED = 2'd3;

   localparam int unsigned ITEMS_PER_PHASE = 115;
   localparam int unsigned DRAIN_CYCLES    = 4;
   localparam int unsigned CYCLE_LIMIT     = 300000;

   // Predict each poll result and hold the results still to come
   class touch_result_scoreboard;
      logic [11:0] width_cfg;
      logic [11:0] height_cfg;
      logic [7:0]  fail_limit_cfg;
      logic [15:0] retry_cfg;
      logic [7:0]  fail_run;
      logic        link_lost;
      logic [31:0] down_since;
      logic [11:0] held_x;
      logic [11:0] held_y;
      logic [31:0] activity;
      rsp_type     pending_results[$];
      int unsigned errors;

      function new();
         width_cfg      = DISPLAY_WIDTH_RESET;
         height_cfg     = DISPLAY_HEIGHT_RESET;
         fail_limit_cfg = FAIL_LIMIT_RESET;
         retry_cfg      = RETRY_INTERVAL_RESET;
         fail_run       = '0;
         link_lost      = 1'b0;
         down_since     = '0;
         held_x         = '0;
         held_y         = '0;
         activity       = '0;
         errors         = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_DISPLAY_WIDTH:  width_cfg = data[11:0];
            CSR_DISPLAY_HEIGHT: height_cfg = data[11:0];
            CSR_FAIL_LIMIT:     fail_limit_cfg = data[7:0];
            CSR_RETRY_INTERVAL: retry_cfg = data;
            default: ;
         endcase
      endfunction

      // Advance the link tracker and the held point for one accepted request
      function void note_request(req_type item);
         rsp_type     res;
         logic [1:0]  ev;
         logic [11:0] rx;
         logic [11:0] ry;
         logic [31:0] elapsed;
         res = '0;
         if (item.action == ACTION_RECONNECT) begin
            link_lost = 1'b0;
            fail_run  = '0;
         end else if (link_lost) begin
            elapsed = item.now_ms - down_since;
            if (elapsed >= 32'(retry_cfg)) begin
               down_since    = item.now_ms;
               res.retry_due = 1'b1;
            end
         end else if (!item.transfer_ok) begin
            if (fail_run != FAIL_COUNT_MAX) fail_run++;
            if (fail_run >= fail_limit_cfg) begin
               link_lost  = 1'b1;
               down_since = item.now_ms;
            end
         end else begin
            ev = item.event_xhigh_byte[7:6];
            rx = {item.event_xhigh_byte[3:0], item.x_low_byte};
            ry = {item.y_high_byte[3:0], item.y_low_byte};
            fail_run = '0;
            if (item.count_byte != 8'd0 && (ev == EVENT_DOWN || ev == EVENT_CONTACT) &&
                32'(rx) < NATIVE_WIDTH && 32'(ry) < NATIVE_HEIGHT) begin
               held_x      = 12'((32'(rx) * 32'(width_cfg)) / NATIVE_WIDTH);
               held_y      = 12'((32'(ry) * 32'(height_cfg)) / NATIVE_HEIGHT);
               activity    = item.now_ms;
               res.pressed = 1'b1;
            end
         end
         res.touch_x          = held_x;
         res.touch_y          = held_y;
         res.link_down        = link_lost;
         res.last_activity_ms = activity;
         pending_results.push_back(res);
      endfunction

      function void check_field(string name, longint unsigned want, longint unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
         end
      endfunction

      // Compare one accepted response with the oldest expected result
      function void check_response(rsp_type got);
         rsp_type want;
         if (pending_results.size() == 0) begin
            $error("response with no request outstanding: %h", got);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         check_field("pressed", want.pressed, got.pressed);
         check_field("touch_x", want.touch_x, got.touch_x);
         check_field("touch_y", want.touch_y, got.touch_y);
         check_field("link_down", want.link_down, got.link_down);
         check_field("retry_due", want.retry_due, got.retry_due);
         check_field("last_activity_ms", want.last_activity_ms, got.last_activity_ms);
      endfunction

      function int unsigned pending();
         return pending_results.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   logic                   no_idle = 1'b0;
   logic [31:0]            tick_ms = '0;
   logic [7:0]             cur_fail_limit = FAIL_LIMIT_RESET;
   int unsigned            fail_burst = 0;
   int unsigned            cycles = 0;

   touch_result_scoreboard sb = new();

   touch_frame_decode_scale_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #1 clock = ~clock;

   // Stall the response side at random, except in the no-idle stretch
   always @(posedge clock) begin
      rsp_ready <= no_idle || ($urandom_range(0, 99) >= 28);
   end

   // Check every accepted response
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_payload);
   end

   // Bound the run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("** touch_frame_decode_scale_unit: FAILED **");
         $finish;
      end
   end

   function automatic req_type noise_request(logic [31:0] tick);
      req_type item;
      item.action           = 1'($urandom);
      item.transfer_ok      = 1'($urandom);
      item.count_byte       = 8'($urandom);
      item.event_xhigh_byte = 8'($urandom);
      item.x_low_byte       = 8'($urandom);
      item.y_high_byte      = 8'($urandom);
      item.y_low_byte       = 8'($urandom);
      item.now_ms           = tick;
      return item;
   endfunction

   function automatic req_type make_frame(logic [7:0] count, logic [1:0] ev, logic [11:0] rx,
                                          logic [11:0] ry, logic [31:0] tick);
      req_type item;
      item.action           = ACTION_POLL;
      item.transfer_ok      = 1'b1;
      item.count_byte       = count;
      item.event_xhigh_byte = {ev, 2'($urandom), rx[11:8]};
      item.x_low_byte       = rx[7:0];
      item.y_high_byte      = {4'($urandom), ry[11:8]};
      item.y_low_byte       = ry[7:0];
      item.now_ms           = tick;
      return item;
   endfunction

   function automatic req_type make_failure(logic [31:0] tick);
      req_type item;
      item             = noise_request(tick);
      item.action      = ACTION_POLL;
      item.transfer_ok = 1'b0;
      return item;
   endfunction

   function automatic req_type make_reconnect(logic [31:0] tick);
      req_type item;
      item        = noise_request(tick);
      item.action = ACTION_RECONNECT;
      return item;
   endfunction

   // Move the millisecond tick: mostly small steps, sometimes long gaps, wraps and jumps
   function automatic logic [31:0] advance_tick();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 80) tick_ms = tick_ms + $urandom_range(0, 400);
      else if (pick < 90) tick_ms = tick_ms + $urandom_range(0, 70000);
      else if (pick < 95) tick_ms = 32'hFFFF_FF00 + $urandom_range(0, 255);
      else tick_ms = $urandom;
      return tick_ms;
   endfunction

   function automatic logic [11:0] grid_coord(int unsigned native);
      if ($urandom_range(0, 7) == 0) return ($urandom_range(0, 1) != 0) ? 12'(native - 1) : 12'd0;
      return 12'($urandom_range(0, native - 1));
   endfunction

   // Mostly good contacts and failure bursts, the rest rejects, reconnects and noise
   function automatic req_type random_request();
      logic [31:0] tick;
      logic [7:0]  count;
      logic [1:0]  ev;
      logic [11:0] rx;
      logic [11:0] ry;
      int unsigned pick;
      tick  = advance_tick();
      count = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'd1;
      ev    = ($urandom_range(0, 1) != 0) ? EVENT_CONTACT : EVENT_DOWN;
      rx    = grid_coord(NATIVE_WIDTH);
      ry    = grid_coord(NATIVE_HEIGHT);
      if (fail_burst > 0) begin
         fail_burst--;
         return make_failure(tick);
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) return make_frame(count, ev, rx, ry, tick);
      if (pick < 67) begin
         case ($urandom_range(0, 3))
            0: count = 8'd0;
            1: ev = ($urandom_range(0, 1) != 0) ? EVENT_UP : EVENT_RESERVED;
            2: rx = 12'($urandom_range(NATIVE_WIDTH, 4095));
            default: ry = 12'($urandom_range(NATIVE_HEIGHT, 4095));
         endcase
         return make_frame(count, ev, rx, ry, tick);
      end
      if (pick < 79) begin
         if ($urandom_range(0, 2) == 0) fail_burst = $urandom_range(0, int'(cur_fail_limit) + 1);
         else fail_burst = $urandom_range(0, 3);
         return make_failure(tick);
      end
      if (pick < 85) return make_reconnect(tick);
      return noise_request(tick);
   endfunction

   // Drive one request; idle first at random, hold valid until accepted
   task automatic send_request(req_type item);
      while (!no_idle && $urandom_range(0, 99) < 28) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      sb.note_request(item);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_register(idx, data);
   endtask

   task automatic apply_settings(logic [15:0] dw, logic [15:0] dh, logic [15:0] fl,
                                 logic [15:0] ri);
      write_csr(CSR_DISPLAY_WIDTH, dw);
      write_csr(CSR_DISPLAY_HEIGHT, dh);
      write_csr(CSR_FAIL_LIMIT, fl);
      write_csr(CSR_RETRY_INTERVAL, ri);
      csr_valid      <= 1'b0;
      cur_fail_limit = fl[7:0];
   endtask

   // Drop valid and hold until every expected result is back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(logic [15:0] dw, logic [15:0] dh, logic [15:0] fl,
                            logic [15:0] ri, logic quiet);
      apply_settings(dw, dh, fl, ri);
      no_idle    <= quiet;
      fail_burst = 0;
      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
         if (n == 57 || $urandom_range(0, 199) == 0) wait_idle();
         send_request(random_request());
      end
      wait_idle();
      no_idle <= 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Register defaults: grid corners, every reject reason, reconnect while up
      send_request(make_frame(8'd1, EVENT_DOWN, 12'd0, 12'd0, 32'd0));
      send_request(make_frame(8'd255, EVENT_CONTACT, 12'(NATIVE_WIDTH - 1),
                              12'(NATIVE_HEIGHT - 1), 32'd10));
      send_request(make_frame(8'd0, EVENT_DOWN, 12'd100, 12'd100, 32'd20));
      send_request(make_frame(8'd1, EVENT_UP, 12'd100, 12'd100, 32'd30));
      send_request(make_frame(8'd1, EVENT_RESERVED, 12'd100, 12'd100, 32'd40));
      send_request(make_frame(8'd1, EVENT_DOWN, 12'(NATIVE_WIDTH), 12'd100, 32'd50));
      send_request(make_frame(8'd1, EVENT_CONTACT, 12'd100, 12'(NATIVE_HEIGHT), 32'd60));
      send_request(make_frame(8'hFF, EVENT_DOWN, 12'hFFF, 12'hFFF, 32'd70));
      send_request(make_reconnect(32'hFFFF_FFFF));
      wait_idle();

      // Widest display, short fail limit: link loss, retry timing, reconnect
      apply_settings(16'd4095, 16'd4095, 16'd2, 16'd100);
      send_request(make_frame(8'd3, EVENT_CONTACT, 12'(NATIVE_WIDTH - 1),
                              12'(NATIVE_HEIGHT - 1), 32'd1000));
      send_request(make_failure(32'd2000));
      send_request(make_failure(32'd2010));
      send_request(make_frame(8'd1, EVENT_DOWN, 12'd5, 12'd5, 32'd2109));
      send_request(make_frame(8'd1, EVENT_DOWN, 12'd5, 12'd5, 32'd2110));
      send_request(make_failure(32'd2111));
      send_request(make_reconnect(32'd3000));
      send_request(make_failure(32'd3001));
      send_request(make_frame(8'd1, EVENT_DOWN, 12'd7, 12'd9, 32'd3002));
      send_request(make_failure(32'd3003));
      wait_idle();

      // Zero display size and zero fail limit, written with stray upper bits
      apply_settings(16'hF000, 16'hF000, 16'hFF00, 16'd0);
      send_request(make_frame(8'd1, EVENT_DOWN, 12'(NATIVE_WIDTH - 1),
                              12'(NATIVE_HEIGHT - 1), 32'hFFFF_FFF0));
      send_request(make_failure(32'hFFFF_FFF8));
      send_request(make_frame(8'd1, EVENT_DOWN, 12'd1, 12'd1, 32'd5));
      send_request(make_failure(32'd5));
      send_request(make_reconnect(32'd6));
      wait_idle();
      tick_ms = 32'd6;

      // Random phases across the register range, one with no random idling
      run_phase(16'd800, 16'd480, 16'd3, 16'd500, 1'b0);
      run_phase(16'd4095, 16'd1, 16'd1, 16'd0, 1'b1);
      run_phase(16'd1, 16'd4095, 16'd255, 16'd65535, 1'b0);
      run_phase(16'($urandom_range(1, 4095)), 16'($urandom_range(1, 4095)),
                16'($urandom_range(1, 20)), 16'($urandom_range(0, 2000)), 1'b0);
      run_phase(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
      run_phase(16'(DISPLAY_WIDTH_RESET), 16'(DISPLAY_HEIGHT_RESET), 16'(FAIL_LIMIT_RESET),
                RETRY_INTERVAL_RESET, 1'b0);

      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("** touch_frame_decode_scale_unit: PASSED **");
      end else begin
         $display("** touch_frame_decode_scale_unit: FAILED **");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/tfds_pkg.sv
rtl/core/touch_frame_decode_scale_unit.sv
dv/tb_top.sv
